### design/krt_pkg.sv
// shared types and codes for the keyed record table
package krt_pkg;

	localparam int KeyW  = 32;
	localparam int WordW = 64;

	typedef logic [1:0] func_t;
	typedef logic [1:0] status_t;

	localparam func_t FUNC_ADD   = 2'd0;
	localparam func_t FUNC_DEL   = 2'd1;
	localparam func_t FUNC_QUERY = 2'd2;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_FULL    = 2'd1;
	localparam status_t ST_MISSING = 2'd2;

	typedef struct packed {
		logic [KeyW-1:0]  key;
		logic [WordW-1:0] word;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_SEND
	} state_t;

endpackage

### design/krt_cell.sv
// one storage cell of the rotating entry ring
module krt_cell (
	input  logic            clk,
	input  logic            shift,
	input  krt_pkg::entry_t d,
	output krt_pkg::entry_t q
);
	import krt_pkg::*;

	entry_t ent_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			ent_q <= d;
		end
	end

	assign q = ent_q;

endmodule

### design/krt_ctrl.sv
// head-of-ring controller: search, append, remove, count and result beat
module krt_ctrl #(
	parameter int CAPACITY = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  krt_pkg::func_t             func,
	input  logic [krt_pkg::KeyW-1:0]   key,
	input  logic [krt_pkg::WordW-1:0]  record_word,
	output logic                       out_valid,
	input  logic                       out_stall,
	output krt_pkg::status_t           status,
	output logic [krt_pkg::WordW-1:0]  found_word,
	output logic [7:0]                 entry_count,
	input  krt_pkg::entry_t            head_ent,
	input  krt_pkg::entry_t            next_ent,
	output krt_pkg::entry_t            tail_ent,
	output logic                       shift
);
	import krt_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [IW-1:0] LastIdx = IW'(CAPACITY - 1);
	localparam logic [CW-1:0] CapCnt  = CW'(CAPACITY);

	state_t state_q, state_nx;

	func_t             op_q;
	logic [KeyW-1:0]   key_q;
	logic [WordW-1:0]  word_q;
	logic [IW-1:0]     idx_q;
	logic [CW-1:0]     count_q;
	logic              found_q;
	logic [WordW-1:0]  fword_q;
	status_t           status_q;
	logic [WordW-1:0]  out_word_q;

	logic              accept;
	logic              last;
	logic              in_range;
	logic              hit;
	logic              skip;
	logic              do_add;
	logic              found_all;
	logic [CW-1:0]     idx_ext;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign idx_ext   = CW'(idx_q);
	assign last      = (idx_q == LastIdx);
	assign in_range  = idx_ext < count_q;
	assign hit       = in_range && (head_ent.key == key_q) && !found_q;
	assign skip      = (op_q == FUNC_DEL) && (found_q || hit);
	assign do_add    = (op_q == FUNC_ADD) && (count_q != CapCnt) && (idx_ext == count_q);
	assign found_all = found_q || hit;

	always_comb begin
		if (do_add) begin
			tail_ent.key  = key_q;
			tail_ent.word = word_q;
		end else if (skip) begin
			tail_ent = next_ent;
		end else begin
			tail_ent = head_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		shift     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_nx = S_RUN;
				end
			end
			S_RUN: begin
				shift = 1'b1;
				if (last) begin
					state_nx = S_SEND;
				end
			end
			S_SEND: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
			found_q <= 1'b0;
		end else if (accept) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (state_q == S_RUN) begin
			idx_q <= idx_q + 1'b1;
			if (hit) begin
				found_q <= 1'b1;
			end
			if (last) begin
				if ((op_q == FUNC_ADD) && (count_q != CapCnt)) begin
					count_q <= count_q + 1'b1;
				end else if ((op_q == FUNC_DEL) && found_all) begin
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= func;
			key_q   <= key;
			word_q  <= record_word;
			fword_q <= '0;
		end else if (state_q == S_RUN) begin
			if (hit) begin
				fword_q <= head_ent.word;
			end
			if (last) begin
				case (op_q)
					FUNC_ADD: begin
						status_q   <= (count_q != CapCnt) ? ST_OK : ST_FULL;
						out_word_q <= '0;
					end
					FUNC_DEL: begin
						status_q   <= found_all ? ST_OK : ST_MISSING;
						out_word_q <= '0;
					end
					FUNC_QUERY: begin
						status_q   <= found_all ? ST_OK : ST_MISSING;
						out_word_q <= found_all ? (hit ? head_ent.word : fword_q) : '0;
					end
					default: begin
						status_q   <= ST_MISSING;
						out_word_q <= '0;
					end
				endcase
			end
		end
	end

	assign status      = status_q;
	assign found_word  = out_word_q;
	assign entry_count = 8'(count_q);

endmodule

### design/keyed_record_table.sv
// top level: bounded unsorted keyed record table on a rotating ring of cells
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+------------------------------------
//  in       | in_valid  | in_stall  | func, key, record_word
//  out      | out_valid | out_stall | status, found_word, entry_count
//
//  one item at a time: the ring rotates once through every cell,
//  then the result beat is offered; a new beat is taken after it leaves
//  the wait from accept to result beat is set by the ring length
//  reset clears the fill count and control; cell contents are never cleared
//  a stalled result beat holds its payload and blocks the next input beat
module keyed_record_table #(
	parameter int CAPACITY = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  krt_pkg::func_t             func,
	input  logic signed [31:0]         key,
	input  logic [63:0]                record_word,
	output logic                       out_valid,
	input  logic                       out_stall,
	output krt_pkg::status_t           status,
	output logic [63:0]                found_word,
	output logic [7:0]                 entry_count
);
	import krt_pkg::*;

	entry_t ring [CAPACITY];
	entry_t tail_ent;
	logic   shift;

	krt_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.key         (KeyW'(key)),
		.record_word (record_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.found_word  (found_word),
		.entry_count (entry_count),
		.head_ent    (ring[0]),
		.next_ent    (ring[1]),
		.tail_ent    (tail_ent),
		.shift       (shift)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == CAPACITY - 1) begin : g_tail
			krt_cell u_cell (
				.clk   (clk),
				.shift (shift),
				.d     (tail_ent),
				.q     (ring[i])
			);
		end else begin : g_body
			krt_cell u_cell (
				.clk   (clk),
				.shift (shift),
				.d     (ring[i+1]),
				.q     (ring[i])
			);
		end
	end

endmodule
